@@ rtl/jss_pkg.sv @@
// jss_pkg: shared types and constants of the jtag scan sequencer
// depends on nothing; imported by every module of the block but jss_fifo
`default_nettype none

package jss_pkg;

  // widths fixed by the command format
  localparam int MAX_SCAN_BITS = 64;
  localparam int LEN_W         = 7;
  localparam int BIT_IDX_W     = $clog2(MAX_SCAN_BITS);

  // clock counts of the tms sequences
  localparam logic [LEN_W-1:0] RESET_CLOCKS   = LEN_W'(5);
  localparam logic [LEN_W-1:0] IR_LEAD_CLOCKS = LEN_W'(4);
  localparam logic [LEN_W-1:0] DR_LEAD_CLOCKS = LEN_W'(3);
  localparam logic [LEN_W-1:0] IR_TMS_HIGH    = LEN_W'(2);
  localparam logic [LEN_W-1:0] MAX_LEN        = LEN_W'(MAX_SCAN_BITS);

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_IDLE  = 2'd1,
    CMD_IR    = 2'd2,
    CMD_DR    = 2'd3
  } jss_cmd_t;

  // classified item passed from front to back
  typedef struct packed {
    logic                     is_tick;
    jss_cmd_t                 command;
    logic [LEN_W-1:0]         scan_length;
    logic [MAX_SCAN_BITS-1:0] shift_data;
    logic                     capture;
    logic                     tdo;
  } jss_item_t;

  // one clock result
  typedef struct packed {
    logic                     tms;
    logic                     tdi;
    logic                     last;
    logic [MAX_SCAN_BITS-1:0] captured;
  } jss_result_t;

endpackage

`default_nettype wire

@@ rtl/jtag_scan_sequencer.sv @@
// jtag_scan_sequencer: one result per tick transfer while a command runs,
// one item per cycle while the result queue has room. Items are registered in
// the item queue, results in the result queue, whose head drives the outputs
// throughput: one input transfer per cycle sustained, set by the sequencer
// taking one queued item each cycle while the result queue has room
// reset: synchronous rst empties both queues, idles the sequencer, held tdi 0
`default_nettype none

module jtag_scan_sequencer
  import jss_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic                     mode,
  input  wire logic [1:0]               command,
  input  wire logic [LEN_W-1:0]         scan_length,
  input  wire logic [MAX_SCAN_BITS-1:0] shift_data,
  input  wire logic                     capture,
  input  wire logic                     tdo,
  output logic                          empty,
  input  wire logic                     pop,
  output logic                          tms,
  output logic                          tdi,
  output logic                          last,
  output logic [MAX_SCAN_BITS-1:0]      captured
);

  jss_item_t   item;
  logic        item_empty;
  logic        item_pop;
  jss_result_t res;
  logic        res_push;
  logic        res_full;
  jss_result_t res_head;

  // front: accept and classify
  jss_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .command     (command),
    .scan_length (scan_length),
    .shift_data  (shift_data),
    .capture     (capture),
    .tdo         (tdo),
    .item        (item),
    .item_empty  (item_empty),
    .item_pop    (item_pop)
  );

  // back: run the tms/tdi sequences
  jss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .res        (res),
    .res_push   (res_push),
    .res_full   (res_full)
  );

  // result queue towards the consumer
  jss_fifo #(
    .WIDTH ($bits(jss_result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign tms      = res_head.tms;
  assign tdi      = res_head.tdi;
  assign last     = res_head.last;
  assign captured = res_head.captured;

endmodule

`default_nettype wire

@@ rtl/jss_fifo.sv @@
// jss_fifo: small flop-based first-in first-out queue
// generic in width and depth; no package dependency
`default_nettype none

module jss_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ rtl/jss_front.sv @@
// jss_front: accepts input transfers, classifies them and queues them
// depends on jss_pkg and jss_fifo
`default_nettype none

module jss_front
  import jss_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic                     mode,
  input  wire logic [1:0]               command,
  input  wire logic [LEN_W-1:0]         scan_length,
  input  wire logic [MAX_SCAN_BITS-1:0] shift_data,
  input  wire logic                     capture,
  input  wire logic                     tdo,
  output jss_item_t                     item,
  output logic                          item_empty,
  input  wire logic                     item_pop
);

  jss_item_t in_item;
  logic [LEN_W-1:0] len_clamped;

  // length clamp: zero is one bit, above the maximum is the maximum
  always_comb begin
    if (scan_length == '0) begin
      len_clamped = LEN_W'(1);
    end else if (scan_length > MAX_LEN) begin
      len_clamped = MAX_LEN;
    end else begin
      len_clamped = scan_length;
    end
  end

  // classify the transfer
  always_comb begin
    in_item             = '0;
    in_item.is_tick     = mode;
    in_item.tdo         = tdo;
    if (!mode) begin
      in_item.command     = jss_cmd_t'(command);
      in_item.scan_length = len_clamped;
      in_item.shift_data  = shift_data;
      in_item.capture     = capture;
    end
  end

  jss_fifo #(
    .WIDTH ($bits(jss_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_item),
    .full  (full),
    .pop   (item_pop),
    .rdata (item),
    .empty (item_empty)
  );

endmodule

`default_nettype wire

@@ rtl/jss_back.sv @@
// jss_back: tms/tdi sequencer that runs queued commands one clock per tick
// depends on jss_pkg
`default_nettype none

module jss_back
  import jss_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire jss_item_t item,
  input  wire logic  item_empty,
  output logic       item_pop,
  output jss_result_t res,
  output logic       res_push,
  input  wire logic  res_full
);

  logic                     busy, busy_next;
  jss_cmd_t                 active_command, active_command_next;
  logic [LEN_W-1:0]         phase_count, phase_count_next;
  logic [LEN_W-1:0]         bits_left, bits_left_next;
  logic [LEN_W-1:0]         scan_len, scan_len_next;
  logic                     capture_on, capture_on_next;
  logic                     held_tdi, held_tdi_next;
  logic [MAX_SCAN_BITS-1:0] shift_reg, shift_reg_next;
  logic [MAX_SCAN_BITS-1:0] capture_reg, capture_reg_next;
  logic [LEN_W-1:0]         lead;
  logic [LEN_W-1:0]         shift_pos;
  logic [BIT_IDX_W-1:0]     bit_idx;
  logic                     is_scan;

  assign is_scan   = (item.command == CMD_IR) || (item.command == CMD_DR);
  assign lead      = (active_command == CMD_IR) ? IR_LEAD_CLOCKS : DR_LEAD_CLOCKS;
  assign shift_pos = phase_count - lead;
  assign bit_idx   = shift_pos[BIT_IDX_W-1:0];

  // sequencer next state and clock result
  always_comb begin
    busy_next           = busy;
    active_command_next = active_command;
    phase_count_next    = phase_count;
    bits_left_next      = bits_left;
    scan_len_next       = scan_len;
    capture_on_next     = capture_on;
    held_tdi_next       = held_tdi;
    shift_reg_next      = shift_reg;
    capture_reg_next    = capture_reg;
    item_pop            = 1'b0;
    res_push            = 1'b0;
    res                 = '0;
    res.tdi             = held_tdi;

    if (!item_empty && !res_full) begin
      item_pop = 1'b1;
      if (!item.is_tick) begin
        // new command, dropped while one is running
        if (!busy) begin
          busy_next           = 1'b1;
          active_command_next = item.command;
          phase_count_next    = '0;
          scan_len_next       = item.scan_length;
          bits_left_next      = is_scan ? item.scan_length : '0;
          shift_reg_next      = item.shift_data;
          capture_reg_next    = '0;
          capture_on_next     = is_scan && item.capture;
        end
      end else if (busy) begin
        res_push = 1'b1;
        unique case (active_command)
          CMD_RESET: begin
            res.tms  = 1'b1;
            res.last = (phase_count >= RESET_CLOCKS - LEN_W'(1));
          end
          CMD_IDLE: begin
            res.tms  = 1'b0;
            res.last = 1'b1;
          end
          CMD_IR, CMD_DR: begin
            if (phase_count < lead) begin
              // entry into the shift state
              if (active_command == CMD_IR) begin
                res.tms = (phase_count < IR_TMS_HIGH);
              end else begin
                res.tms = (phase_count == '0);
              end
            end else if (bits_left != '0) begin
              // shift clock, final one leaves the shift state
              res.tdi        = shift_reg[0];
              held_tdi_next  = shift_reg[0];
              shift_reg_next = shift_reg >> 1;
              if (capture_on && item.tdo) begin
                capture_reg_next[bit_idx] = 1'b1;
              end
              res.tms        = (bits_left == LEN_W'(1));
              bits_left_next = bits_left - LEN_W'(1);
            end else if (phase_count == lead + scan_len) begin
              // update state
              res.tms = 1'b1;
            end else begin
              // back to run-test/idle
              res.tms  = 1'b0;
              res.last = 1'b1;
              if (capture_on) begin
                res.captured = capture_reg;
              end
            end
          end
        endcase
        phase_count_next = phase_count + LEN_W'(1);
        if (res.last) begin
          busy_next = 1'b0;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      active_command <= CMD_RESET;
      phase_count    <= '0;
      bits_left      <= '0;
      scan_len       <= '0;
      capture_on     <= 1'b0;
      held_tdi       <= 1'b0;
    end else begin
      busy           <= busy_next;
      active_command <= active_command_next;
      phase_count    <= phase_count_next;
      bits_left      <= bits_left_next;
      scan_len       <= scan_len_next;
      capture_on     <= capture_on_next;
      held_tdi       <= held_tdi_next;
    end
  end

  // shift and capture data
  always_ff @(posedge clk) begin
    shift_reg   <= shift_reg_next;
    capture_reg <= capture_reg_next;
  end

`ifndef SYNTHESIS
  a_result_only_busy: assert property (@(posedge clk) disable iff (rst)
    res_push |-> busy)
    else $error("clock result produced with no command running");

  a_last_ends_command: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.last) |=> !busy)
    else $error("command still running after its final clock");

  a_bits_within_length: assert property (@(posedge clk) disable iff (rst)
    busy |-> (bits_left <= scan_len))
    else $error("shift count exceeds scan length");

  a_reset_cmd_bounded: assert property (@(posedge clk) disable iff (rst)
    (busy && active_command == CMD_RESET) |-> (phase_count < RESET_CLOCKS))
    else $error("reset sequence ran past five clocks");
`endif

endmodule

`default_nettype wire
